// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared definitions
// Field widths, opcodes, cell constants and sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int COLOR_W  = 4;
   localparam int RROW_W   = 5;
   localparam int RCOL_W   = 7;
   localparam int CELL_W   = 16;

   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RADDR,
      ST_RDATA,
      ST_SCROLL,
      ST_DRAIN,
      ST_FILL
   } state_type;

endpackage

// ===== src/tcw_addr_alu.sv =====
// ----------------------------------------------------------------------------
// tcw_addr_alu: shared address adder
// One add with an end-of-range compare, reused by the put, read, scroll and fill steps.
// ----------------------------------------------------------------------------
module tcw_addr_alu #(
   parameter int W = 12
) (
   input  logic [W-1:0] opa,
   input  logic [W-1:0] opb,
   input  logic [W-1:0] limit,
   output logic [W-1:0] sum,
   output logic         hit
);

   assign sum = opa + opb;
   assign hit = (sum == limit);

endmodule

// ===== src/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_ram: character cell store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);

   logic [tcw_pkg::CELL_W-1:0] mem_ff [DEPTH];
   logic [tcw_pkg::CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

// ===== src/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit: text-mode console engine
// ROWS x COLUMNS cell store with cursor; put, clear, read commands.
// ----------------------------------------------------------------------------
//
//  channel   handshake               word
//  -------   ---------------------   ---------------------------------------
//  request   start & !busy           opcode, char, fg, bg, read row/col
//  response  rsp_valid (1 cycle)     cell value, cursor column, cursor row
//
// Commands: a printable character or newline without scroll is answered in the
//   next cycle and the next word is taken right after. A read passes through
//   address multiply, address add and RAM read. A scroll and a clear are both
//   set by the single RAM write port, one cell per cycle.
// Reset: synchronous; a clearing pass blanks the store with busy high, and no
//   response word is produced for it.
// Stalls: the receiver cannot stall; every response is a one-cycle strobe.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tcw_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]          req_char_code,
   input  logic [tcw_pkg::COLOR_W-1:0]         req_fg_color,
   input  logic [tcw_pkg::COLOR_W-1:0]         req_bg_color,
   input  logic [tcw_pkg::RROW_W-1:0]          req_read_row,
   input  logic [tcw_pkg::RCOL_W-1:0]          req_read_col,
   output logic                                rsp_valid,
   output logic [tcw_pkg::CELL_W-1:0]          rsp_cell_value,
   output logic [tcw_pkg::RCOL_W-1:0]          rsp_cursor_col_out,
   output logic [tcw_pkg::RROW_W-1:0]          rsp_cursor_row_out
);

   // geometry
   localparam int CELLS     = ROWS * COLUMNS;
   localparam int CW        = $clog2(COLUMNS);
   localparam int RW        = $clog2(ROWS);
   localparam int AW        = $clog2(CELLS);
   localparam int CNT_W     = $clog2(CELLS + 1);
   localparam int COL_OUT_W = tcw_pkg::RCOL_W;
   localparam int ROW_OUT_W = tcw_pkg::RROW_W;

   localparam logic [CW-1:0]    COL_LAST  = CW'(COLUMNS - 1);
   localparam logic [RW-1:0]    ROW_LAST  = RW'(ROWS - 1);
   localparam logic [CNT_W-1:0] CNT_COLS  = CNT_W'(COLUMNS);
   localparam logic [CNT_W-1:0] CNT_CELLS = CNT_W'(CELLS);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0] LAST_BASE = CNT_W'((ROWS - 1) * COLUMNS);
   localparam logic [8:0]       ROWS_LIM  = 9'(ROWS);
   localparam logic [8:0]       COLS_LIM  = 9'(COLUMNS);

   tcw_pkg::state_type state_ff, state_in;

   // cursor: column/row plus the linear address of the cursor and its row start
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CNT_W-1:0] cur_addr_ff, cur_addr_in;
   logic [CNT_W-1:0] row_base_ff, row_base_in;

   // sweep pointers: ptr_ff reads (scroll) or writes (fill); wptr_ff trails for copy
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] wptr_ff, wptr_in;
   logic             copy_vld_ff, copy_vld_in;
   logic             pend_ff, pend_in;

   // read command operands
   logic [CNT_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0] rcol_ff, rcol_in;

   // response word
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CELL_W-1:0]    rsp_cell_ff, rsp_cell_in;
   logic [COL_OUT_W-1:0]          rsp_col_ff, rsp_col_in;
   logic [ROW_OUT_W-1:0]          rsp_row_ff, rsp_row_in;

   // shared adder
   logic [CNT_W-1:0] alu_a, alu_b, alu_sum;
   logic             alu_hit;

   // RAM ports
   logic                       ram_we, ram_re;
   logic [AW-1:0]              ram_waddr, ram_raddr;
   logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

   // command decode
   logic accept;
   logic is_nl;
   logic wrap;
   logic rd_in_range;
   logic emit;
   logic [tcw_pkg::CELL_W-1:0] emit_cell;

   tcw_addr_alu #(
      .W (CNT_W)
   ) u_alu (
      .opa   (alu_a),
      .opb   (alu_b),
      .limit (CNT_CELLS),
      .sum   (alu_sum),
      .hit   (alu_hit)
   );

   tcw_screen_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy   = (state_ff != tcw_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign is_nl       = (req_char_code == tcw_pkg::NEWLINE_CODE);
   assign wrap        = !is_nl && (col_ff == COL_LAST);
   assign rd_in_range = (9'(req_read_row) < ROWS_LIM) && (9'(req_read_col) < COLS_LIM);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state, RAM and adder control
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cur_addr_in  = cur_addr_ff;
      row_base_in  = row_base_ff;
      ptr_in       = ptr_ff;
      wptr_in      = wptr_ff;
      copy_vld_in  = 1'b0;
      pend_in      = pend_ff;
      base_in      = base_ff;
      rcol_in      = rcol_ff;
      emit         = 1'b0;
      emit_cell    = '0;

      alu_a        = ptr_ff;
      alu_b        = CNT_ONE;

      ram_we       = 1'b0;
      ram_waddr    = wptr_ff[AW-1:0];
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = ptr_ff[AW-1:0];

      // scroll copy write-back, in the cycle after the read
      if (copy_vld_ff) begin
         ram_we  = 1'b1;
         wptr_in = wptr_ff + CNT_ONE;
      end

      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  tcw_pkg::OP_PUT: begin
                     if (is_nl || wrap) begin
                        alu_a = row_base_ff;
                        alu_b = CNT_COLS;
                     end else begin
                        alu_a = cur_addr_ff;
                        alu_b = CNT_ONE;
                     end
                     if (!is_nl) begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_addr_ff[AW-1:0];
                        ram_wdata = {req_bg_color, req_fg_color, req_char_code};
                     end
                     if (is_nl || wrap) begin
                        col_in = '0;
                        if (row_ff == ROW_LAST) begin
                           // bottom line: scroll, cursor stays on last row
                           row_base_in = LAST_BASE;
                           cur_addr_in = LAST_BASE;
                           ptr_in      = CNT_COLS;
                           wptr_in     = '0;
                           pend_in     = 1'b1;
                           state_in    = tcw_pkg::ST_SCROLL;
                        end else begin
                           row_in      = row_ff + RW'(1);
                           row_base_in = alu_sum;
                           cur_addr_in = alu_sum;
                           emit        = 1'b1;
                        end
                     end else begin
                        col_in      = col_ff + CW'(1);
                        cur_addr_in = alu_sum;
                        emit        = 1'b1;
                     end
                  end
                  tcw_pkg::OP_CLEAR: begin
                     col_in      = '0;
                     row_in      = '0;
                     cur_addr_in = '0;
                     row_base_in = '0;
                     ptr_in      = '0;
                     pend_in     = 1'b1;
                     state_in    = tcw_pkg::ST_FILL;
                  end
                  tcw_pkg::OP_READ: begin
                     if (rd_in_range) begin
                        base_in  = CNT_W'(req_read_row) * CNT_COLS;
                        rcol_in  = CNT_W'(req_read_col);
                        state_in = tcw_pkg::ST_RADDR;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         tcw_pkg::ST_RADDR: begin
            alu_a     = base_ff;
            alu_b     = rcol_ff;
            ram_re    = 1'b1;
            ram_raddr = alu_sum[AW-1:0];
            state_in  = tcw_pkg::ST_RDATA;
         end
         tcw_pkg::ST_RDATA: begin
            emit      = 1'b1;
            emit_cell = ram_rdata;
            state_in  = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_SCROLL: begin
            ram_re      = 1'b1;
            copy_vld_in = 1'b1;
            ptr_in      = alu_sum;
            if (alu_hit) begin
               state_in = tcw_pkg::ST_DRAIN;
            end
         end
         tcw_pkg::ST_DRAIN: begin
            // last copy write lands here; then blank the bottom row
            ptr_in   = LAST_BASE;
            state_in = tcw_pkg::ST_FILL;
         end
         tcw_pkg::ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff[AW-1:0];
            ram_wdata = tcw_pkg::BLANK_CELL;
            ptr_in    = alu_sum;
            if (alu_hit) begin
               emit     = pend_ff;
               pend_in  = 1'b0;
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = emit;
      rsp_cell_in  = emit_cell;
      rsp_col_in   = COL_OUT_W'(col_in);
      rsp_row_in   = ROW_OUT_W'(row_in);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         cur_addr_ff  <= '0;
         row_base_ff  <= '0;
         ptr_ff       <= '0;
         wptr_ff      <= '0;
         copy_vld_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         cur_addr_ff  <= cur_addr_in;
         row_base_ff  <= row_base_in;
         ptr_ff       <= ptr_in;
         wptr_ff      <= wptr_in;
         copy_vld_ff  <= copy_vld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      rcol_ff     <= rcol_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_value     = rsp_cell_ff;
   assign rsp_cursor_col_out = rsp_col_ff;
   assign rsp_cursor_row_out = rsp_row_ff;

`ifndef ASSERT_OFF
   // a plain character without line wrap answers in the next cycle
   a_put_fast: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == tcw_pkg::OP_PUT) && !is_nl && (col_ff != COL_LAST)
      |=> rsp_valid)
      else $error("put character did not respond in one cycle");

   // cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (CW'(col_ff) <= COL_LAST) && (RW'(row_ff) <= ROW_LAST))
      else $error("cursor off screen");

   // linear cursor address tracks row start plus column
   a_cursor_addr: assert property (@(posedge clock) disable iff (reset)
      cur_addr_ff == row_base_ff + CNT_W'(col_ff))
      else $error("cursor address out of step");

   // blank fill never shares the write port with a scroll copy
   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_FILL) |-> !copy_vld_ff)
      else $error("write port collision");
`endif

endmodule
